>>> src/fdrq_pkg.sv
// Shared constants, action codes and the request record for the frame
// descriptor ring queue. No dependencies.
`default_nettype none
package fdrq_pkg;

  localparam int DefSlots      = 8;
  localparam int DefSlotBytes  = 65536;
  localparam int DefMaxPackets = 16;

  localparam logic [2:0] ACT_BEGIN  = 3'd0;
  localparam logic [2:0] ACT_APPEND = 3'd1;
  localparam logic [2:0] ACT_COMMIT = 3'd2;
  localparam logic [2:0] ACT_ABORT  = 3'd3;
  localparam logic [2:0] ACT_PEEK   = 3'd4;
  localparam logic [2:0] ACT_POP    = 3'd5;

  localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

  // One request after the state update, waiting for the descriptor reads.
  typedef struct packed {
    logic [2:0]  action;
    logic        status;
    logic [18:0] address;
    logic [16:0] length;
    logic        index_ok;
    logic [63:0] now_time;
    logic [3:0]  depth;
    logic [31:0] overflow_count;
    logic [31:0] oversize_count;
  } pend_t;

endpackage
`default_nettype wire

>>> src/fdrq_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none
module fdrq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> src/fdrq_ctrl.sv
// Queue control: ring pointers, open-frame state and drop counters, memory
// writes and reads per request, and the stage that waits for read data.
// Depends on fdrq_pkg.
`default_nettype none
module fdrq_ctrl #(
  parameter int SLOTS       = fdrq_pkg::DefSlots,
  parameter int SLOT_BYTES  = fdrq_pkg::DefSlotBytes,
  parameter int MAX_PACKETS = fdrq_pkg::DefMaxPackets,
  localparam int SW   = $clog2(SLOTS),
  localparam int CW   = $clog2(SLOTS + 1),
  localparam int WBW  = $clog2(SLOT_BYTES + 1),
  localparam int PCW  = $clog2(MAX_PACKETS + 1),
  localparam int PAW  = $clog2(SLOTS * MAX_PACKETS),
  localparam int FRW  = 64 + PCW + WBW
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              accept,
  input  wire logic              advance,
  input  wire logic [2:0]        action,
  input  wire logic [63:0]       now_time,
  input  wire logic [15:0]       header_length,
  input  wire logic [15:0]       first_payload_length,
  input  wire logic [15:0]       second_payload_length,
  input  wire logic [3:0]        packet_index,
  output      logic              ready,
  output      logic              frame_we,
  output      logic [SW-1:0]     frame_waddr,
  output      logic [FRW-1:0]    frame_wdata,
  output      logic [SW-1:0]     frame_raddr,
  output      logic              pkt_we,
  output      logic [PAW-1:0]    pkt_waddr,
  output      logic [32:0]       pkt_wdata,
  output      logic [PAW-1:0]    pkt_raddr,
  output      logic              pend_valid,
  output      fdrq_pkg::pend_t   pend
);

  localparam int SUMW = ((WBW > 18) ? WBW : 18) + 1;

  logic [SW-1:0]  head_slot, head_slot_next;
  logic [CW-1:0]  frame_count, frame_count_next;
  logic           write_open, write_open_next;
  logic [WBW-1:0] write_bytes, write_bytes_next;
  logic [PCW-1:0] write_packet_count, write_packet_count_next;
  logic [63:0]    write_begin_time, write_begin_time_next;
  logic [31:0]    overflow_total, overflow_total_next;
  logic [31:0]    oversize_total, oversize_total_next;
  fdrq_pkg::pend_t pend_next;

  logic [SW:0]     slot_sum;
  logic [SW-1:0]   tail_slot;
  logic [17:0]     total;
  logic [SUMW-1:0] bytes_sum;
  logic            over_limit;
  logic [31:0]     base_head;
  logic [31:0]     base_write;
  logic [31:0]     pkt_w_idx;
  logic [31:0]     pkt_r_idx;

  assign ready = !pend_valid || advance;

  always_comb begin
    slot_sum   = (SW + 1)'(head_slot) + (SW + 1)'(frame_count);
    tail_slot  = (slot_sum >= (SW + 1)'(SLOTS)) ? SW'(slot_sum - (SW + 1)'(SLOTS))
                                                : SW'(slot_sum);
    total      = 18'(header_length) + 18'(first_payload_length)
               + 18'(second_payload_length);
    bytes_sum  = SUMW'(write_bytes) + SUMW'(total);
    over_limit = (write_packet_count >= PCW'(MAX_PACKETS))
              || (bytes_sum > SUMW'(SLOT_BYTES));
    base_head  = 32'(head_slot) * 32'(SLOT_BYTES);
    base_write = 32'(tail_slot) * 32'(SLOT_BYTES) + 32'(write_bytes);
    pkt_w_idx  = 32'(tail_slot) * 32'(MAX_PACKETS) + 32'(write_packet_count);
    pkt_r_idx  = 32'(head_slot) * 32'(MAX_PACKETS) + 32'(packet_index);
  end

  assign frame_waddr = tail_slot;
  assign frame_wdata = {write_begin_time, write_packet_count, write_bytes};
  assign frame_raddr = head_slot;
  assign pkt_waddr   = pkt_w_idx[PAW-1:0];
  assign pkt_wdata   = {16'(write_bytes), 17'(total)};
  assign pkt_raddr   = pkt_r_idx[PAW-1:0];

  always_comb begin
    head_slot_next          = head_slot;
    frame_count_next        = frame_count;
    write_open_next         = write_open;
    write_bytes_next        = write_bytes;
    write_packet_count_next = write_packet_count;
    write_begin_time_next   = write_begin_time;
    overflow_total_next     = overflow_total;
    oversize_total_next     = oversize_total;
    frame_we                = 1'b0;
    pkt_we                  = 1'b0;
    pend_next               = '0;
    pend_next.action        = action;
    pend_next.status        = 1'b1;
    pend_next.now_time      = now_time;
    pend_next.index_ok      = 32'(packet_index) < 32'(MAX_PACKETS);

    case (action)
      fdrq_pkg::ACT_BEGIN: begin
        write_open_next = 1'b0;
        if (frame_count == CW'(SLOTS)) begin
          if (overflow_total != fdrq_pkg::CNT_MAX) begin
            overflow_total_next = overflow_total + 32'd1;
          end
        end else begin
          write_bytes_next        = '0;
          write_packet_count_next = '0;
          write_begin_time_next   = now_time;
          write_open_next         = 1'b1;
          pend_next.status        = 1'b0;
        end
      end
      fdrq_pkg::ACT_APPEND: begin
        if (write_open && header_length != 16'd0) begin
          if (over_limit) begin
            // drop the whole frame
            write_open_next = 1'b0;
            if (oversize_total != fdrq_pkg::CNT_MAX) begin
              oversize_total_next = oversize_total + 32'd1;
            end
          end else begin
            pkt_we                  = accept;
            pend_next.address       = base_write[18:0];
            pend_next.length        = 17'(total);
            write_bytes_next        = WBW'(bytes_sum);
            write_packet_count_next = write_packet_count + PCW'(1);
            pend_next.status        = 1'b0;
          end
        end
      end
      fdrq_pkg::ACT_COMMIT: begin
        if (write_open && write_packet_count != '0) begin
          frame_we         = accept;
          frame_count_next = frame_count + CW'(1);
          pend_next.status = 1'b0;
        end
        write_open_next = 1'b0;
      end
      fdrq_pkg::ACT_ABORT: begin
        write_open_next  = 1'b0;
        pend_next.status = 1'b0;
      end
      fdrq_pkg::ACT_PEEK: begin
        if (frame_count != '0) begin
          pend_next.address = base_head[18:0];
          pend_next.status  = 1'b0;
        end
      end
      fdrq_pkg::ACT_POP: begin
        if (frame_count != '0) begin
          head_slot_next   = (head_slot == SW'(SLOTS - 1)) ? '0 : head_slot + SW'(1);
          frame_count_next = frame_count - CW'(1);
          pend_next.status = 1'b0;
        end
      end
      default: begin
      end
    endcase

    pend_next.depth          = 4'(frame_count_next);
    pend_next.overflow_count = overflow_total_next;
    pend_next.oversize_count = oversize_total_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_slot          <= '0;
      frame_count        <= '0;
      write_open         <= 1'b0;
      write_bytes        <= '0;
      write_packet_count <= '0;
      write_begin_time   <= '0;
      overflow_total     <= '0;
      oversize_total     <= '0;
      pend_valid         <= 1'b0;
    end else begin
      if (accept) begin
        head_slot          <= head_slot_next;
        frame_count        <= frame_count_next;
        write_open         <= write_open_next;
        write_bytes        <= write_bytes_next;
        write_packet_count <= write_packet_count_next;
        write_begin_time   <= write_begin_time_next;
        overflow_total     <= overflow_total_next;
        oversize_total     <= oversize_total_next;
        pend_valid         <= 1'b1;
      end else if (advance) begin
        pend_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend <= pend_next;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    frame_count <= CW'(SLOTS))
    else $error("frame count exceeds ring size");

  a_bytes_bound: assert property (@(posedge clk) disable iff (rst)
    write_bytes <= WBW'(SLOT_BYTES) && write_packet_count <= PCW'(MAX_PACKETS))
    else $error("open frame exceeds slot limits");

  a_pop_step: assert property (@(posedge clk) disable iff (rst)
    accept && action == fdrq_pkg::ACT_POP && frame_count != '0
      |=> frame_count == $past(frame_count) - CW'(1))
    else $error("pop did not retire one frame");

  a_accept_ready: assert property (@(posedge clk) disable iff (rst)
    accept |-> ready)
    else $error("request taken while stage busy");
`endif

endmodule
`default_nettype wire

>>> src/frame_descriptor_ring_queue.sv
// Frame descriptor ring queue. Accepts one request per cycle when the result
// side keeps up; each result is registered behind two register stages: the
// registered read of the frame and packet descriptor memories, then the
// output register. Requests: begin, append, commit, abort, peek, pop. Each
// request gives exactly one result. Descriptor memories need no clearing
// after reset; the block is ready as soon as rst falls.
// Depends on fdrq_pkg, fdrq_ctrl and fdrq_ram.
`default_nettype none
module frame_descriptor_ring_queue #(
  parameter int SLOTS       = fdrq_pkg::DefSlots,
  parameter int SLOT_BYTES  = fdrq_pkg::DefSlotBytes,
  parameter int MAX_PACKETS = fdrq_pkg::DefMaxPackets
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output      logic         s_tready,
  // now_time[63:0], header_length[79:64], first_payload_length[95:80],
  // second_payload_length[111:96], packet_index[115:112], zero pad
  input  wire logic [119:0] s_tdata,
  // action[2:0]
  input  wire logic [2:0]   s_tuser,
  output      logic         m_tvalid,
  input  wire logic         m_tready,
  // address[18:0], length[35:19], packet_offset[51:36], frame_packets[56:52],
  // frame_bytes[73:57], enqueue_time[137:74], age_us[169:138], depth[173:170],
  // overflow_count[205:174], oversize_count[237:206], zero pad
  output      logic [239:0] m_tdata,
  // status[0]
  output      logic [0:0]   m_tuser
);

  localparam int SW  = $clog2(SLOTS);
  localparam int WBW = $clog2(SLOT_BYTES + 1);
  localparam int PCW = $clog2(MAX_PACKETS + 1);
  localparam int PAW = $clog2(SLOTS * MAX_PACKETS);
  localparam int FRW = 64 + PCW + WBW;

  logic            accept;
  logic            advance;
  logic            frame_we;
  logic [SW-1:0]   frame_waddr;
  logic [FRW-1:0]  frame_wdata;
  logic [SW-1:0]   frame_raddr;
  logic [FRW-1:0]  frame_rdata;
  logic            pkt_we;
  logic [PAW-1:0]  pkt_waddr;
  logic [32:0]     pkt_wdata;
  logic [PAW-1:0]  pkt_raddr;
  logic [32:0]     pkt_rdata;
  logic            pend_valid;
  fdrq_pkg::pend_t pend;

  logic [63:0]  fr_time;
  logic [31:0]  age;
  logic         peek_ok;
  logic         pop_ok;
  logic [237:0] result;

  assign advance = !m_tvalid || m_tready;
  assign accept  = s_tvalid && s_tready;

  fdrq_ctrl #(
    .SLOTS       (SLOTS),
    .SLOT_BYTES  (SLOT_BYTES),
    .MAX_PACKETS (MAX_PACKETS)
  ) u_ctrl (
    .clk                   (clk),
    .rst                   (rst),
    .accept                (accept),
    .advance               (advance),
    .action                (s_tuser),
    .now_time              (s_tdata[63:0]),
    .header_length         (s_tdata[79:64]),
    .first_payload_length  (s_tdata[95:80]),
    .second_payload_length (s_tdata[111:96]),
    .packet_index          (s_tdata[115:112]),
    .ready                 (s_tready),
    .frame_we              (frame_we),
    .frame_waddr           (frame_waddr),
    .frame_wdata           (frame_wdata),
    .frame_raddr           (frame_raddr),
    .pkt_we                (pkt_we),
    .pkt_waddr             (pkt_waddr),
    .pkt_wdata             (pkt_wdata),
    .pkt_raddr             (pkt_raddr),
    .pend_valid            (pend_valid),
    .pend                  (pend)
  );

  // Read only when a request is taken so stalled read data holds.
  fdrq_ram #(
    .WIDTH (FRW),
    .DEPTH (SLOTS)
  ) u_frame_ram (
    .clk   (clk),
    .we    (frame_we),
    .waddr (frame_waddr),
    .wdata (frame_wdata),
    .re    (accept),
    .raddr (frame_raddr),
    .rdata (frame_rdata)
  );

  fdrq_ram #(
    .WIDTH (33),
    .DEPTH (SLOTS * MAX_PACKETS)
  ) u_pkt_ram (
    .clk   (clk),
    .we    (pkt_we),
    .waddr (pkt_waddr),
    .wdata (pkt_wdata),
    .re    (accept),
    .raddr (pkt_raddr),
    .rdata (pkt_rdata)
  );

  always_comb begin
    fr_time = frame_rdata[FRW-1 -: 64];
    age     = (pend.now_time > fr_time) ? 32'(pend.now_time - fr_time) : 32'd0;
    peek_ok = pend.action == fdrq_pkg::ACT_PEEK && !pend.status;
    pop_ok  = pend.action == fdrq_pkg::ACT_POP && !pend.status;
    result  = '0;
    result[18:0]  = pend.address;
    result[35:19] = pend.length;
    if (peek_ok) begin
      if (pend.index_ok) begin
        result[35:19] = pkt_rdata[16:0];
        result[51:36] = pkt_rdata[32:17];
      end
      result[56:52]   = 5'(frame_rdata[WBW +: PCW]);
      result[73:57]   = 17'(frame_rdata[WBW-1:0]);
      result[137:74]  = fr_time;
    end
    if (peek_ok || pop_ok) begin
      result[169:138] = age;
    end
    result[173:170] = pend.depth;
    result[205:174] = pend.overflow_count;
    result[237:206] = pend.oversize_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= pend_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && pend_valid) begin
      m_tdata <= {2'b00, result};
      m_tuser <= pend.status;
    end
  end

endmodule
`default_nettype wire

>>> test/fdrq_checker.sv
// Scoreboard for the frame descriptor ring queue: tracks the ring, the open
// frame and the descriptor tables, predicts each request's result and compares.
// Depends on fdrq_pkg for the action codes and the default sizes.
`timescale 1ns / 100ps
module fdrq_checker
  import fdrq_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  input  wire logic         s_tready,
  input  wire logic [119:0] s_tdata,
  input  wire logic [2:0]   s_tuser,
  input  wire logic         m_tvalid,
  input  wire logic         m_tready,
  input  wire logic [239:0] m_tdata,
  input  wire logic [0:0]   m_tuser,
  output int                fail_count,
  output int                pending
);

  localparam int Slots      = DefSlots;
  localparam int SlotBytes  = DefSlotBytes;
  localparam int MaxPackets = DefMaxPackets;

  typedef struct packed {
    logic        status;
    logic [18:0] address;
    logic [16:0] length;
    logic [15:0] pkt_offset;
    logic [4:0]  frame_pkts;
    logic [16:0] frame_bytes;
    logic [63:0] enq_time;
    logic [31:0] age;
    logic [3:0]  depth;
    logic [31:0] overflow_cnt;
    logic [31:0] oversize_cnt;
  } outcome_t;

  logic [2:0]  ring_head;
  logic [3:0]  queued;
  logic        building;
  logic [16:0] build_bytes;
  logic [4:0]  build_pkts;
  logic [63:0] build_start;
  logic [63:0] slot_start [Slots];
  logic [16:0] slot_bytes [Slots];
  logic [4:0]  slot_pkts [Slots];
  logic [15:0] pkt_offset_tab [Slots*MaxPackets];
  logic [16:0] pkt_len_tab [Slots*MaxPackets];
  logic [31:0] overflow_drops;
  logic [31:0] limit_drops;

  outcome_t owed_results[$];
  int       result_no;

  task automatic report(string msg);
    $display("[%0t] result %0d: %s", $time, result_no, msg);
    fail_count++;
  endtask

  task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want) begin
      report($sformatf("%s got %0h expected %0h", name, got, want));
    end
  endtask

  function automatic logic [31:0] sojourn(logic [63:0] now, logic [63:0] since);
    logic [63:0] diff;
    diff = now - since;
    return (now > since) ? diff[31:0] : 32'd0;
  endfunction

  // Apply one request to the tracked ring and return the result it owes.
  function automatic outcome_t advance_ring(logic [2:0] act, logic [63:0] now,
                                            logic [15:0] hdr, logic [15:0] pay1,
                                            logic [15:0] pay2, logic [3:0] idx);
    outcome_t    o;
    logic [17:0] total;
    logic [2:0]  wslot;
    int          entry;
    o = '0;
    o.status = 1'b1;
    // 3-bit add wraps around the eight slots
    wslot = ring_head + queued[2:0];
    total = 18'(hdr) + 18'(pay1) + 18'(pay2);
    case (act)
      ACT_BEGIN: begin
        building = 1'b0;
        if (int'(queued) >= Slots) begin
          if (overflow_drops != CNT_MAX) overflow_drops++;
        end else begin
          build_bytes = '0;
          build_pkts  = '0;
          build_start = now;
          building    = 1'b1;
          o.status    = 1'b0;
        end
      end
      ACT_APPEND: begin
        if (building && hdr != 16'd0) begin
          if (int'(build_pkts) >= MaxPackets ||
              int'(build_bytes) + int'(total) > SlotBytes) begin
            building = 1'b0;
            if (limit_drops != CNT_MAX) limit_drops++;
          end else begin
            entry = int'(wslot) * MaxPackets + int'(build_pkts);
            pkt_offset_tab[entry] = build_bytes[15:0];
            pkt_len_tab[entry]    = total[16:0];
            o.address   = 19'(int'(wslot) * SlotBytes + int'(build_bytes));
            o.length    = total[16:0];
            build_bytes = build_bytes + total[16:0];
            build_pkts  = build_pkts + 5'd1;
            o.status    = 1'b0;
          end
        end
      end
      ACT_COMMIT: begin
        if (building && build_pkts != 5'd0) begin
          slot_start[wslot] = build_start;
          slot_bytes[wslot] = build_bytes;
          slot_pkts[wslot]  = build_pkts;
          queued   = queued + 4'd1;
          o.status = 1'b0;
        end
        building = 1'b0;
      end
      ACT_ABORT: begin
        building = 1'b0;
        o.status = 1'b0;
      end
      ACT_PEEK: begin
        if (queued != 4'd0) begin
          // a position past the frame's packet count still reads the stored entry
          if (int'(idx) < MaxPackets) begin
            entry = int'(ring_head) * MaxPackets + int'(idx);
            o.length     = pkt_len_tab[entry];
            o.pkt_offset = pkt_offset_tab[entry];
          end
          o.address     = 19'(int'(ring_head) * SlotBytes);
          o.frame_pkts  = slot_pkts[ring_head];
          o.frame_bytes = slot_bytes[ring_head];
          o.enq_time    = slot_start[ring_head];
          o.age         = sojourn(now, slot_start[ring_head]);
          o.status      = 1'b0;
        end
      end
      ACT_POP: begin
        if (queued != 4'd0) begin
          o.age     = sojourn(now, slot_start[ring_head]);
          ring_head = ring_head + 3'd1;
          queued    = queued - 4'd1;
          o.status  = 1'b0;
        end
      end
      default: ;
    endcase
    o.depth        = queued;
    o.overflow_cnt = overflow_drops;
    o.oversize_cnt = limit_drops;
    return o;
  endfunction

  always @(posedge clk) begin : watch
    outcome_t got;
    outcome_t want;
    if (rst) begin
      ring_head      = '0;
      queued         = '0;
      building       = 1'b0;
      build_bytes    = '0;
      build_pkts     = '0;
      build_start    = '0;
      overflow_drops = '0;
      limit_drops    = '0;
      owed_results.delete();
      result_no      = 0;
      pending       <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.status       = m_tuser[0];
        got.address      = m_tdata[18:0];
        got.length       = m_tdata[35:19];
        got.pkt_offset   = m_tdata[51:36];
        got.frame_pkts   = m_tdata[56:52];
        got.frame_bytes  = m_tdata[73:57];
        got.enq_time     = m_tdata[137:74];
        got.age          = m_tdata[169:138];
        got.depth        = m_tdata[173:170];
        got.overflow_cnt = m_tdata[205:174];
        got.oversize_cnt = m_tdata[237:206];
        if (owed_results.size() == 0) begin
          report("result with no request waiting");
        end else begin
          want = owed_results.pop_front();
          check_field("status", got.status, want.status);
          check_field("address", got.address, want.address);
          check_field("length", got.length, want.length);
          check_field("packet_offset", got.pkt_offset, want.pkt_offset);
          check_field("frame_packets", got.frame_pkts, want.frame_pkts);
          check_field("frame_bytes", got.frame_bytes, want.frame_bytes);
          check_field("enqueue_time", got.enq_time, want.enq_time);
          check_field("age_us", got.age, want.age);
          check_field("depth", got.depth, want.depth);
          check_field("overflow_count", got.overflow_cnt, want.overflow_cnt);
          check_field("oversize_count", got.oversize_cnt, want.oversize_cnt);
        end
        result_no++;
      end
      if (s_tvalid && s_tready) begin
        owed_results.push_back(advance_ring(s_tuser, s_tdata[63:0], s_tdata[79:64],
                                            s_tdata[95:80], s_tdata[111:96],
                                            s_tdata[115:112]));
      end
      pending <= owed_results.size();
    end
  end

endmodule

>>> test/tb_top.sv
// Top of the frame descriptor ring queue testbench: clock, reset, request
// stimulus with idle and stall phases, and the verdict.
// Depends on fdrq_pkg, frame_descriptor_ring_queue and fdrq_checker.
`timescale 1ns / 100ps
module tb_top;
  import fdrq_pkg::*;

  localparam int Items = 1700;
  localparam logic [2:0] ACT_SPARE_LO = 3'd6;
  localparam logic [2:0] ACT_SPARE_HI = 3'd7;
  localparam logic [63:0] TIME_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  // now_time, header_length, first_payload_length, second_payload_length,
  // packet_index, zero pad
  logic [119:0] s_tdata = '0;
  // action
  logic [2:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  // address, length, packet_offset, frame_packets, frame_bytes, enqueue_time,
  // age_us, depth, overflow_count, oversize_count, zero pad
  logic [239:0] m_tdata;
  // status
  logic [0:0]   m_tuser;

  int          fail_count;
  int          pending;
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          sent = 0;
  logic [63:0] clock_us = '0;

  frame_descriptor_ring_queue uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  fdrq_checker chk (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Send one request, idling first as the current phase asks.
  task automatic issue(logic [2:0] act, logic [63:0] now, logic [15:0] hdr,
                       logic [15:0] pay1, logic [15:0] pay2, logic [3:0] idx);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {4'h0, idx, pay2, pay1, hdr, now};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
  endtask

  // Hold the request side until every owed result is back.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [63:0] pick_time();
    case ($urandom_range(9))
      0: return {$urandom, $urandom};
      // jump far enough that ages wrap past 32 bits
      1: clock_us += {$urandom_range(1, 3), $urandom};
      default: clock_us += 64'($urandom_range(0, 2000));
    endcase
    return clock_us;
  endfunction

  function automatic logic [15:0] pick_len(int max_len);
    return ($urandom_range(3) == 0) ? 16'h0 : 16'($urandom_range(1, max_len));
  endfunction

  task automatic build_frame(int npk, int max_len);
    logic [15:0] hdr;
    issue(ACT_BEGIN, pick_time(), 16'($urandom), 16'($urandom), 16'($urandom),
          4'($urandom));
    repeat (npk) begin
      hdr = ($urandom_range(24) == 0) ? 16'h0 : 16'($urandom_range(1, max_len));
      issue(ACT_APPEND, {$urandom, $urandom}, hdr, pick_len(max_len), pick_len(max_len),
            4'($urandom));
    end
    case ($urandom_range(19))
      0, 1: issue(ACT_ABORT, {$urandom, $urandom}, 16'($urandom), 16'($urandom),
                  16'($urandom), 4'($urandom));
      2: ;  // leave it open; the next begin drops it
      default: issue(ACT_COMMIT, {$urandom, $urandom}, 16'($urandom), 16'($urandom),
                     16'($urandom), 4'($urandom));
    endcase
  endtask

  initial begin
    int per_phase;
    int stop_at;
    int pick;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty ring and no open frame
    issue(ACT_POP, 64'd0, 16'd0, 16'd0, 16'd0, 4'd0);
    issue(ACT_PEEK, TIME_MAX, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'hF);
    issue(ACT_APPEND, 64'd0, 16'hFFFF, 16'd0, 16'd0, 4'd0);
    issue(ACT_COMMIT, 64'd0, 16'd0, 16'd0, 16'd0, 4'd0);
    issue(ACT_ABORT, 64'd0, 16'd0, 16'd0, 16'd0, 4'd0);
    issue(ACT_SPARE_LO, TIME_MAX, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'hF);
    issue(ACT_SPARE_HI, 64'd0, 16'd0, 16'd0, 16'd0, 4'd0);
    // zero header refused, then commit of an empty frame refused
    issue(ACT_BEGIN, 64'd0, 16'd0, 16'd0, 16'd0, 4'd0);
    issue(ACT_APPEND, 64'd0, 16'h0, 16'd7, 16'd7, 4'd0);
    issue(ACT_COMMIT, 64'd0, 16'd0, 16'd0, 16'd0, 4'd0);
    // fill a slot to the last byte
    issue(ACT_BEGIN, TIME_MAX - 64'd15, 16'd0, 16'd0, 16'd0, 4'd0);
    issue(ACT_APPEND, 64'd0, 16'hFFFF, 16'd0, 16'd0, 4'd0);
    issue(ACT_APPEND, 64'd0, 16'd1, 16'd0, 16'd0, 4'd0);
    issue(ACT_COMMIT, 64'd0, 16'd0, 16'd0, 16'd0, 4'd0);
    issue(ACT_PEEK, 64'd0, 16'd0, 16'd0, 16'd0, 4'd1);
    issue(ACT_PEEK, TIME_MAX, 16'd0, 16'd0, 16'd0, 4'd0);
    // over the byte limit: frame dropped, later append refused
    issue(ACT_BEGIN, 64'd100, 16'd0, 16'd0, 16'd0, 4'd0);
    issue(ACT_APPEND, 64'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd0);
    issue(ACT_APPEND, 64'd0, 16'd5, 16'd0, 16'd0, 4'd0);
    // begin over an open frame drops it
    issue(ACT_BEGIN, 64'd7, 16'd0, 16'd0, 16'd0, 4'd0);
    issue(ACT_APPEND, 64'd0, 16'd9, 16'd0, 16'd0, 4'd0);
    issue(ACT_BEGIN, 64'h10, 16'd0, 16'd0, 16'd0, 4'd0);
    issue(ACT_APPEND, 64'd0, 16'd1, 16'd2, 16'd3, 4'd0);
    issue(ACT_COMMIT, 64'd0, 16'd0, 16'd0, 16'd0, 4'd0);
    issue(ACT_POP, 64'd0, 16'd0, 16'd0, 16'd0, 4'd0);
    issue(ACT_PEEK, 64'h1_0000_0020, 16'd0, 16'd0, 16'd0, 4'd0);
    issue(ACT_POP, TIME_MAX, 16'd0, 16'd0, 16'd0, 4'd0);

    // write every descriptor of every slot so any later peek index is defined
    for (int f = 0; f < DefSlots; f++) begin
      issue(ACT_BEGIN, pick_time(), 16'($urandom), 16'($urandom), 16'($urandom),
            4'($urandom));
      repeat (DefMaxPackets) begin
        issue(ACT_APPEND, {$urandom, $urandom}, 16'($urandom_range(1, 255)),
              16'($urandom_range(0, 255)), 16'($urandom_range(0, 255)), 4'($urandom));
      end
      issue(ACT_COMMIT, {$urandom, $urandom}, 16'($urandom), 16'($urandom),
            16'($urandom), 4'($urandom));
    end
    // ring full: begin overflows and nothing is open
    issue(ACT_BEGIN, pick_time(), 16'd0, 16'd0, 16'd0, 4'd0);
    issue(ACT_APPEND, 64'd0, 16'd1, 16'd0, 16'd0, 4'd0);

    per_phase = (Items - sent) / 4;
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 88; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 88; end
        default: begin idle_pct = 38; stall_pct = 38; end
      endcase
      stop_at = sent + per_phase;
      while (sent < stop_at) begin
        pick = $urandom_range(99);
        if (pick < 38) begin
          case ($urandom_range(9))
            0: build_frame($urandom_range(16, 18), 600);  // runs into the packet limit
            1: build_frame($urandom_range(1, 4), 65535);  // mostly over the byte limit
            default: build_frame($urandom_range(1, 6), 1500);
          endcase
        end else if (pick < 52) begin
          issue(ACT_PEEK, pick_time(), 16'($urandom), 16'($urandom), 16'($urandom),
                4'($urandom));
        end else if (pick < 74) begin
          issue(ACT_POP, pick_time(), 16'($urandom), 16'($urandom), 16'($urandom),
                4'($urandom));
        end else if (pick < 88) begin
          issue(ACT_PEEK, pick_time(), 16'($urandom), 16'($urandom), 16'($urandom),
                4'($urandom));
          issue(ACT_POP, pick_time(), 16'($urandom), 16'($urandom), 16'($urandom),
                4'($urandom));
        end else begin
          issue(3'($urandom), {$urandom, $urandom}, 16'($urandom), 16'($urandom),
                16'($urandom), 4'($urandom));
        end
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
